// ----- rtl/mma_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI message assembler package
// Shared widths, action codes, parser modes and the MIDI data length table.
// ----------------------------------------------------------------------------
package mma_pkg;

   localparam int ByteWidth   = 8;
   localparam int DataWidth   = 7;
   localparam int ActionWidth = 3;
   localparam int LengthWidth = 2;

   // Result action codes.
   localparam logic [ActionWidth-1:0] ACT_NONE        = 3'd0;
   localparam logic [ActionWidth-1:0] ACT_COMPLETE    = 3'd1;
   localparam logic [ActionWidth-1:0] ACT_SYSEX_START = 3'd2;
   localparam logic [ActionWidth-1:0] ACT_SYSEX_DATUM = 3'd3;
   localparam logic [ActionWidth-1:0] ACT_SYSEX_END   = 3'd4;

   // Data length codes returned by the status table.
   localparam logic [1:0] LEN_NONE  = 2'd0;
   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_SYSEX = 2'd3;

   localparam logic [ByteWidth-1:0] SYSEX_START_BYTE = 8'hF0;
   localparam logic [ByteWidth-1:0] SYSEX_END_BYTE   = 8'hF7;

   typedef enum logic [2:0] {
      MODE_WAIT_STATUS = 3'b001,
      MODE_WAIT_DATA   = 3'b010,
      MODE_SYSEX       = 3'b100
   } mode_type;

   // Number of data bytes that follow a status byte; LEN_SYSEX marks an
   // open-ended system exclusive message.
   function automatic logic [1:0] data_len(input logic [ByteWidth-1:0] s);
      logic [1:0] len;
      unique case (s) inside
         [8'h80:8'hBF]: len = LEN_TWO;
         [8'hC0:8'hDF]: len = LEN_ONE;
         [8'hE0:8'hEF]: len = LEN_TWO;
         8'hF0:         len = LEN_SYSEX;
         8'hF1, 8'hF3:  len = LEN_ONE;
         8'hF2:         len = LEN_TWO;
         default:       len = LEN_NONE;
      endcase
      return len;
   endfunction

endpackage

// ----- rtl/mma_channels.sv -----
// ----------------------------------------------------------------------------
// MIDI message assembler channels
// Valid/ready interfaces for the byte input and the message result channel.
// ----------------------------------------------------------------------------
interface mma_req_if;
   import mma_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] midi_byte;

   modport source (output valid, output midi_byte, input ready);
   modport sink   (input valid, input midi_byte, output ready);
endinterface

interface mma_rsp_if;
   import mma_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ActionWidth-1:0] action;
   logic [ByteWidth-1:0]   status_byte;
   logic [DataWidth-1:0]   first_data;
   logic [DataWidth-1:0]   second_data;
   logic [LengthWidth-1:0] message_length;

   modport source (output valid, output action, output status_byte, output first_data,
                   output second_data, output message_length, input ready);
   modport sink   (input valid, input action, input status_byte, input first_data,
                   input second_data, input message_length, output ready);
endinterface

// ----- rtl/midi_message_assembler.sv -----
// A result is registered and presented in the cycle after its byte transaction is accepted.
// Throughput: one byte per cycle while the result channel is not stalled; the parser
// update feeds the result register, which is refilled in the same cycle it is taken.
// Reset: synchronous, active high; the parser returns to waiting for a status
// byte with empty counts, the result register empties and no byte is taken.
// ----------------------------------------------------------------------------
// MIDI message assembler
// Parses a MIDI byte stream into channel, system and SysEx events, giving
// exactly one result transaction for every byte transaction.
// ----------------------------------------------------------------------------
module midi_message_assembler #(
   parameter int MAX_MESSAGE_BYTES = 3
) (
   input logic        clock,
   input logic        reset,
   mma_req_if.sink    req_if,
   mma_rsp_if.source  rsp_if
);
   import mma_pkg::*;

   // The fill count has to reach the buffer depth itself.
   localparam int FillWidth = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam logic [FillWidth-1:0] FillMax   = FillWidth'(MAX_MESSAGE_BYTES);
   localparam logic [FillWidth-1:0] FillZero  = FillWidth'(0);
   localparam logic [FillWidth-1:0] FillOne   = FillWidth'(1);
   localparam logic [FillWidth-1:0] FillTwo   = FillWidth'(2);

   // Parser state.
   mode_type             mode_ff, mode_in;
   logic [1:0]           remaining_ff, remaining_in;
   logic [FillWidth-1:0] fill_ff, fill_in;

   // Message buffer. Only the status byte and the first two data bytes are
   // ever shown, so deeper entries are counted but not stored. Data bytes
   // have bit 7 clear and are held in seven bits.
   logic [ByteWidth-1:0] status_buf_ff, status_buf_in;
   logic [DataWidth-1:0] first_buf_ff, first_buf_in;
   logic [DataWidth-1:0] second_buf_ff, second_buf_in;

   // Result register.
   logic                   rsp_valid_ff;
   logic [ActionWidth-1:0] action_ff, action_in;
   logic [ByteWidth-1:0]   status_out_ff, status_out_in;
   logic [DataWidth-1:0]   first_out_ff, first_out_in;
   logic [DataWidth-1:0]   second_out_ff, second_out_in;
   logic [LengthWidth-1:0] length_out_ff, length_out_in;

   logic                 accept;
   logic                 is_status;
   logic                 take_status;
   logic                 sysex_result;
   logic [ByteWidth-1:0] in_byte;

   // A new byte is taken whenever the result register is empty or is being
   // emptied in this cycle, so bytes stream through at one per cycle.
   assign req_if.ready = !reset && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;
   assign in_byte      = req_if.midi_byte;
   assign is_status    = in_byte[ByteWidth-1];

   always_comb begin
      mode_in       = mode_ff;
      remaining_in  = remaining_ff;
      fill_in       = fill_ff;
      status_buf_in = status_buf_ff;
      first_buf_in  = first_buf_ff;
      second_buf_in = second_buf_ff;
      action_in     = ACT_NONE;
      sysex_result  = 1'b0;
      take_status   = 1'b0;

      unique case (mode_ff)
         MODE_SYSEX: begin
            // Data is passed on byte by byte; end of SysEx closes the
            // message and any other status byte starts a fresh one.
            if (!is_status) begin
               action_in    = ACT_SYSEX_DATUM;
               sysex_result = 1'b1;
            end else if (in_byte == SYSEX_END_BYTE) begin
               mode_in      = MODE_WAIT_STATUS;
               action_in    = ACT_SYSEX_END;
               sysex_result = 1'b1;
            end else begin
               take_status = 1'b1;
            end
         end
         MODE_WAIT_DATA: begin
            if (!is_status) begin
               if (fill_ff == FillOne) begin
                  first_buf_in = in_byte[DataWidth-1:0];
               end
               if (fill_ff == FillTwo) begin
                  second_buf_in = in_byte[DataWidth-1:0];
               end
               // A byte that finds the buffer full is dropped but still
               // counts towards completion.
               if (fill_ff < FillMax) begin
                  fill_in = fill_ff + FillOne;
               end
               remaining_in = remaining_ff - 2'd1;
               if (remaining_in == 2'd0) begin
                  mode_in   = MODE_WAIT_STATUS;
                  action_in = ACT_COMPLETE;
               end
            end else begin
               take_status = 1'b1;
            end
         end
         default: begin
            // A stray data byte while waiting for status changes nothing.
            take_status = is_status;
         end
      endcase

      // A status byte restarts the builder, except a SysEx end inside SysEx; real-time
      // bytes take no data and so abort whatever was in progress.
      if (take_status) begin
         status_buf_in = in_byte;
         fill_in       = FillOne;
         case (data_len(in_byte))
            LEN_NONE: begin
               remaining_in = 2'd0;
               mode_in      = MODE_WAIT_STATUS;
               action_in    = ACT_COMPLETE;
            end
            LEN_SYSEX: begin
               remaining_in = 2'd0;
               mode_in      = MODE_SYSEX;
               action_in    = ACT_SYSEX_START;
            end
            default: begin
               remaining_in = data_len(in_byte);
               mode_in      = MODE_WAIT_DATA;
            end
         endcase
      end
   end

   // Apart from SysEx data and end results, the result shows the buffer as it
   // stands after this byte; entries at or beyond the fill count read as zero.
   always_comb begin
      if (sysex_result) begin
         status_out_in = SYSEX_START_BYTE;
         first_out_in  = (action_in == ACT_SYSEX_DATUM) ? in_byte[DataWidth-1:0]
                                                        : DataWidth'(0);
         second_out_in = DataWidth'(0);
         length_out_in = LengthWidth'(1);
      end else begin
         status_out_in = (fill_in > FillZero) ? status_buf_in : ByteWidth'(0);
         first_out_in  = (fill_in > FillOne) ? first_buf_in : DataWidth'(0);
         second_out_in = (fill_in > FillTwo) ? second_buf_in : DataWidth'(0);
         length_out_in = fill_in[LengthWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_WAIT_STATUS;
         remaining_ff <= 2'd0;
         fill_ff      <= FillZero;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff      <= mode_in;
            remaining_ff <= remaining_in;
            fill_ff      <= fill_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_buf_ff <= status_buf_in;
         first_buf_ff  <= first_buf_in;
         second_buf_ff <= second_buf_in;
         action_ff     <= action_in;
         status_out_ff <= status_out_in;
         first_out_ff  <= first_out_in;
         second_out_ff <= second_out_in;
         length_out_ff <= length_out_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.action         = action_ff;
   assign rsp_if.status_byte    = status_out_ff;
   assign rsp_if.first_data     = first_out_ff;
   assign rsp_if.second_data    = second_out_ff;
   assign rsp_if.message_length = length_out_ff;

`ifndef SYNTHESIS
   // Every accepted byte leaves a result waiting in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_if.valid)
      else $error("accepted byte produced no result");

   // Data bytes inside SysEx are reported as SysEx data.
   a_sysex_datum: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == MODE_SYSEX && !req_if.midi_byte[7])
      |=> (rsp_if.action == ACT_SYSEX_DATUM && rsp_if.first_data == $past(req_if.midi_byte[6:0])))
      else $error("SysEx data byte not reported as datum");

   // Real-time bytes complete at once as single-byte messages.
   a_realtime: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.midi_byte[7:3] == 5'b11111)
      |=> (rsp_if.action == ACT_COMPLETE && rsp_if.message_length == 2'd1))
      else $error("real-time byte did not complete immediately");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI message assembler testbench
// Plays a byte stream (a directed opening, then mostly well-formed channel,
// system and SysEx messages mixed with broken sequences and noise) into the
// assembler in bursts. The receiver stalls on its own pattern. Every result
// transaction is compared field by field with a software copy of the parser.
// ----------------------------------------------------------------------------
module testbench;
   import mma_pkg::*;

   localparam int MaxMessageBytes = 3;
   localparam int RandomItems     = 500;
   localparam int WatchdogLimit   = 1000;
   localparam int DrainCycles     = 16;

   // One result transaction as the assembler presents it.
   typedef struct packed {
      logic [ActionWidth-1:0] action;
      logic [ByteWidth-1:0]   status_byte;
      logic [DataWidth-1:0]   first_data;
      logic [DataWidth-1:0]   second_data;
      logic [LengthWidth-1:0] message_length;
   } midi_event_type;

   // Receiver behaviour, chosen afresh for each window of cycles.
   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PATTERN,
      STALL_HOLD
   } stall_style_type;

   // Keeps its own copy of the parser state and works out, for every accepted
   // byte, the event that the assembler should report. Reported events are
   // matched in order against the oldest pending one.
   class midi_event_scoreboard;
      mode_type             assembly_mode;
      int                   remaining;
      int                   held;
      logic [ByteWidth-1:0] held_bytes [MaxMessageBytes];
      midi_event_type       pending_events [$];
      int                   mismatches;
      int                   action_counts [5];

      function new();
         assembly_mode = MODE_WAIT_STATUS;
         remaining     = 0;
         held          = 0;
         mismatches    = 0;
         foreach (action_counts[i]) action_counts[i] = 0;
      endfunction

      // Data bytes that follow a status byte in the MIDI table.
      static function logic [1:0] data_byte_count(logic [ByteWidth-1:0] s);
         if (s < 8'hC0) return LEN_TWO;
         if (s < 8'hE0) return LEN_ONE;
         if (s < 8'hF0) return LEN_TWO;
         case (s)
            8'hF0:        return LEN_SYSEX;
            8'hF1, 8'hF3: return LEN_ONE;
            8'hF2:        return LEN_TWO;
            default:      return LEN_NONE;
         endcase
      endfunction

      function midi_event_type buffered_event(logic [ActionWidth-1:0] act);
         midi_event_type ev;
         ev.action         = act;
         ev.status_byte    = (held > 0) ? held_bytes[0] : '0;
         ev.first_data     = (held > 1) ? held_bytes[1][DataWidth-1:0] : '0;
         ev.second_data    = (held > 2) ? held_bytes[2][DataWidth-1:0] : '0;
         ev.message_length = LengthWidth'(held);
         return ev;
      endfunction

      function midi_event_type sysex_event(logic [ActionWidth-1:0] act,
                                           logic [DataWidth-1:0] datum);
         midi_event_type ev;
         ev.action         = act;
         ev.status_byte    = SYSEX_START_BYTE;
         ev.first_data     = datum;
         ev.second_data    = '0;
         ev.message_length = LengthWidth'(1);
         return ev;
      endfunction

      function midi_event_type assemble(logic [ByteWidth-1:0] midi_in);
         logic       is_status;
         logic [1:0] len_code;
         is_status = midi_in[7];
         if (assembly_mode == MODE_SYSEX) begin
            if (!is_status) return sysex_event(ACT_SYSEX_DATUM, midi_in[DataWidth-1:0]);
            if (midi_in == SYSEX_END_BYTE) begin
               assembly_mode = MODE_WAIT_STATUS;
               return sysex_event(ACT_SYSEX_END, '0);
            end
         end else if (assembly_mode == MODE_WAIT_DATA && !is_status) begin
            // A byte that finds the buffer full still counts towards completion.
            if (held < MaxMessageBytes) begin
               held_bytes[held] = midi_in;
               held++;
            end
            remaining = (remaining - 1) & 3;
            if (remaining == 0) begin
               assembly_mode = MODE_WAIT_STATUS;
               return buffered_event(ACT_COMPLETE);
            end
            return buffered_event(ACT_NONE);
         end

         // A stray data byte leaves everything as it was.
         if (!is_status) return buffered_event(ACT_NONE);

         // Any other status byte, real-time ones included, restarts the builder.
         held_bytes[0] = midi_in;
         held          = 1;
         len_code      = data_byte_count(midi_in);
         if (len_code == LEN_NONE) begin
            remaining     = 0;
            assembly_mode = MODE_WAIT_STATUS;
            return buffered_event(ACT_COMPLETE);
         end
         if (len_code == LEN_SYSEX) begin
            remaining     = 0;
            assembly_mode = MODE_SYSEX;
            return buffered_event(ACT_SYSEX_START);
         end
         remaining     = int'(len_code);
         assembly_mode = MODE_WAIT_DATA;
         return buffered_event(ACT_NONE);
      endfunction

      function void note_byte(logic [ByteWidth-1:0] midi_in);
         midi_event_type ev;
         ev = assemble(midi_in);
         if (ev.action <= ACT_SYSEX_END) action_counts[ev.action]++;
         pending_events.push_back(ev);
      endfunction

      function void compare_field(string field, logic [ByteWidth-1:0] want,
                                  logic [ByteWidth-1:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_event(midi_event_type got);
         midi_event_type want;
         if (pending_events.size() == 0) begin
            $error("result transaction with nothing pending: action %0d", got.action);
            mismatches++;
            return;
         end
         want = pending_events.pop_front();
         compare_field("action", ByteWidth'(want.action), ByteWidth'(got.action));
         compare_field("status_byte", want.status_byte, got.status_byte);
         compare_field("first_data", ByteWidth'(want.first_data), ByteWidth'(got.first_data));
         compare_field("second_data", ByteWidth'(want.second_data),
                       ByteWidth'(got.second_data));
         compare_field("message_length", ByteWidth'(want.message_length),
                       ByteWidth'(got.message_length));
      endfunction
   endclass

   logic clock;
   logic reset;

   mma_req_if req_chan ();
   mma_rsp_if rsp_chan ();

   midi_message_assembler #(
      .MAX_MESSAGE_BYTES(MaxMessageBytes)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   midi_event_scoreboard sb;
   logic [ByteWidth-1:0] byte_stream [$];
   int                   bytes_accepted;
   int                   idle_cycles;
   int                   directed_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Stream construction. Most of the random part is well-formed messages with
   // random content, so that the data and SysEx states are visited often; the
   // rest is truncated messages, real-time interruptions and raw noise.
   // ------------------------------------------------------------------------
   function automatic logic [ByteWidth-1:0] random_data();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'h7F;
      return ByteWidth'($urandom_range(0, 127));
   endfunction

   function automatic logic [ByteWidth-1:0] random_channel_status();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 8'h80;
      if (pick == 1) return 8'hEF;
      return ByteWidth'($urandom_range(8'h80, 8'hEF));
   endfunction

   function automatic void append_data(int count);
      for (int i = 0; i < count; i++) byte_stream.push_back(random_data());
   endfunction

   function automatic void append_random_message();
      int                   kind;
      int                   needed;
      logic [ByteWidth-1:0] status;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         // Complete channel voice message.
         status = random_channel_status();
         byte_stream.push_back(status);
         append_data(int'(midi_event_scoreboard::data_byte_count(status)));
      end else if (kind < 55) begin
         // System common, including the undefined codes and a stray SysEx end.
         status = ByteWidth'($urandom_range(8'hF1, 8'hF7));
         byte_stream.push_back(status);
         append_data(int'(midi_event_scoreboard::data_byte_count(status)));
      end else if (kind < 70) begin
         // SysEx block, usually closed properly, sometimes cut short by a
         // different status byte or simply left open.
         byte_stream.push_back(SYSEX_START_BYTE);
         append_data($urandom_range(0, 6));
         needed = $urandom_range(0, 9);
         if (needed < 8) byte_stream.push_back(SYSEX_END_BYTE);
         else if (needed == 8) byte_stream.push_back(ByteWidth'($urandom_range(8'h80, 8'hFF)));
      end else if (kind < 78) begin
         byte_stream.push_back(ByteWidth'($urandom_range(8'hF8, 8'hFF)));
      end else if (kind < 88) begin
         // Message broken off before all of its data has arrived.
         status = random_channel_status();
         byte_stream.push_back(status);
         needed = int'(midi_event_scoreboard::data_byte_count(status));
         append_data($urandom_range(0, needed - 1));
      end else if (kind < 94) begin
         // Real-time byte in the middle of a message; the data after it is stray.
         status = ByteWidth'($urandom_range(8'h80, 8'hBF));
         byte_stream.push_back(status);
         append_data(1);
         byte_stream.push_back(ByteWidth'($urandom_range(8'hF8, 8'hFF)));
         append_data(1);
      end else begin
         for (int i = 0; i < $urandom_range(1, 4); i++)
            byte_stream.push_back(ByteWidth'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void append_directed();
      logic [ByteWidth-1:0] opening [$];
      // Stray data before any status, note off at the data extremes, the
      // system common codes F1 and F2, the undefined codes, SysEx end outside SysEx,
      // real-time codes (one of them aborting a control change), a SysEx
      // block interrupted by a program change, and an empty SysEx block.
      opening = '{8'h00,
                  8'h80, 8'h00, 8'h7F,
                  8'hF1, 8'h55,
                  8'hF2, 8'h00, 8'h2A,
                  8'hF4, 8'hF5, 8'hF6, 8'hF7,
                  8'hF8,
                  8'hB0, 8'h07, 8'hFF, 8'h64,
                  8'hF0, 8'h7F, 8'h00, 8'hC3, 8'h2A,
                  8'hF0, 8'hF7};
      foreach (opening[i]) byte_stream.push_back(opening[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Sender. Bytes go out in bursts of random length separated by random gaps;
   // inputs change only at the falling edge, and a byte is held until the
   // monitor has seen its transaction accepted.
   // ------------------------------------------------------------------------
   task automatic play_stream();
      int idx;
      int burst;
      int gap;
      int target;
      idx = 0;
      while (idx < byte_stream.size()) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         for (int k = 0; k < burst && idx < byte_stream.size(); k++) begin
            target             = bytes_accepted + 1;
            req_chan.valid     <= 1'b1;
            req_chan.midi_byte <= byte_stream[idx];
            idx++;
            do @(negedge clock); while (bytes_accepted < target);
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            // Junk on the payload while valid is low must be ignored.
            repeat (gap) begin
               req_chan.midi_byte <= ByteWidth'($urandom);
               @(negedge clock);
            end
         end
      end
      req_chan.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Receiver. Each window of cycles picks a stall style: always ready,
   // random stalls, a repeating 8-bit pattern, or a long hold at the start.
   // ------------------------------------------------------------------------
   initial begin
      stall_style_type      style;
      logic [7:0]           pattern;
      int                   hold;
      rsp_chan.ready = 1'b0;
      forever begin
         style   = stall_style_type'($urandom_range(0, 3));
         pattern = 8'($urandom) | 8'h01;
         hold    = $urandom_range(1, 15);
         for (int c = 0; c < 48; c++) begin
            @(negedge clock);
            case (style)
               STALL_NONE:    rsp_chan.ready <= 1'b1;
               STALL_RANDOM:  rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               STALL_PATTERN: rsp_chan.ready <= pattern[c % 8];
               default:       rsp_chan.ready <= (c >= hold);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. Samples both channels at the rising edge: an accepted byte
   // transaction adds a prediction, an accepted result transaction is checked
   // against the oldest one. It also keeps the count of idle cycles for the
   // watchdog.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      midi_event_type got;
      logic           any_accept;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         any_accept = 1'b0;
         if (req_chan.valid && req_chan.ready) begin
            sb.note_byte(req_chan.midi_byte);
            bytes_accepted++;
            any_accept = 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.action         = rsp_chan.action;
            got.status_byte    = rsp_chan.status_byte;
            got.first_data     = rsp_chan.first_data;
            got.second_data    = rsp_chan.second_data;
            got.message_length = rsp_chan.message_length;
            sb.check_event(got);
            any_accept = 1'b1;
         end
         idle_cycles <= any_accept ? 0 : idle_cycles + 1;
      end
   end

   // Watchdog: too long without any transaction means the block has hung.
   initial begin
      @(negedge clock);
      while (idle_cycles < WatchdogLimit) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence: reset, play the stream, let the results drain, report.
   // ------------------------------------------------------------------------
   initial begin
      sb                 = new();
      bytes_accepted     = 0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.midi_byte = '0;

      append_directed();
      directed_count = byte_stream.size();
      while (byte_stream.size() < directed_count + RandomItems) append_random_message();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      play_stream();

      // Wait until every predicted result has been checked, then a little longer
      // so that any surplus result would be caught.
      while (sb.pending_events.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("summary: %0d byte transactions (%0d directed), %0d field mismatches",
               bytes_accepted, directed_count, sb.mismatches);
      $display("summary: results by action: none %0d, complete %0d, sysex start %0d, %s %0d, %s %0d",
               sb.action_counts[ACT_NONE], sb.action_counts[ACT_COMPLETE],
               sb.action_counts[ACT_SYSEX_START], "sysex datum",
               sb.action_counts[ACT_SYSEX_DATUM], "sysex end",
               sb.action_counts[ACT_SYSEX_END]);
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mma_pkg.sv
rtl/mma_channels.sv
rtl/midi_message_assembler.sv
dv/testbench.sv
